### rtl/slug_pkg.sv
// Constants and types shared by the shuffled Lehmer uniform generator.
package slug_pkg;

    // Lehmer generator: state <- state * 16807 mod (2^31 - 1)
    localparam int unsigned         STATE_W       = 31;
    localparam int unsigned         MULT_W        = 15;
    localparam int unsigned         PROD_W        = STATE_W + MULT_W;
    localparam logic [MULT_W-1:0]   LCG_MULT      = 15'd16807;
    localparam logic [STATE_W-1:0]  LCG_MOD       = 31'h7FFF_FFFF;
    localparam logic [STATE_W-1:0]  SEED_DEFAULT  = 31'd1;

    // Discarded generator steps before the table fill
    localparam int unsigned         WARMUP_STEPS  = 8;

    // Default depth of the shuffle table
    localparam int unsigned         TABLE_DEPTH_DEF = 32;

    // Q0.24 fraction: raw * 2^24 + (2^31-2)/2, split into a high add and
    // a low part of all ones
    localparam int unsigned         FRAC_W        = 24;
    localparam logic [STATE_W:0]    FRAC_HI_ADD   = 32'd63;
    localparam logic [FRAC_W-1:0]   FRAC_LO_ONES  = 24'hFF_FFFF;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_SEL   = 7'b000_0010,
        S_MUL   = 7'b000_0100,
        S_FOLD  = 7'b000_1000,
        S_FRAC  = 7'b001_0000,
        S_CARRY = 7'b010_0000,
        S_OUT   = 7'b100_0000
    } t_state;

endpackage

### rtl/shuffled_lcg_uniform_generator.sv
// Shuffled Lehmer uniform generator with a Bays-Durham table, top level.
//
// Usage
//   Request channel: i_valid / o_ready with i_reseed. Each transfer yields
//   exactly one result on o_valid / i_ready with o_raw_value (1 .. 2^31-2)
//   and o_unit_fraction (raw / (2^31-1) in Q0.24, rounded, saturated).
//   Seed register: i_seed_value is written on any edge with i_seed_we high;
//   a seed of 0 or 2^31-1 is used as 1. Write it only while idle.
// Request flow
//   After a transfer the request passes the registered reciprocal-multiply
//   table index, the multiply and fold steps of the modular unit with the
//   table read, and the fraction and carry steps that round the fraction,
//   then the output step and idle; a new request is taken only in idle.
//   The first request after reset, and every request with i_reseed high,
//   first runs 8 + TABLE_DEPTH generator steps, each a multiply and a fold,
//   to load the table.
// Reset
//   i_rst_n (synchronous, active low) clears the sequencer, the output
//   valid and the table-loaded flag; the seed register returns to 1.
// Stall
//   A finished result waits in the output register; one new request may be
//   taken and processed meanwhile, holding in its last step until the
//   output register is free.
module shuffled_lcg_uniform_generator
    import slug_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // seed register
    input  logic                i_seed_we,
    input  logic [STATE_W-1:0]  i_seed_value,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_reseed,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATE_W-1:0]  o_raw_value,
    output logic [FRAC_W-1:0]   o_unit_fraction
);

    localparam int unsigned TW      = $clog2(TABLE_DEPTH);
    localparam int unsigned STEPS   = WARMUP_STEPS + TABLE_DEPTH;
    localparam int unsigned CW      = $clog2(STEPS);
    localparam int unsigned SEL_DIV = 1 + (2147483646 / TABLE_DEPTH);
    localparam int unsigned REC_L   = $clog2(SEL_DIV);
    localparam int unsigned REC_SH  = STATE_W + REC_L;
    localparam logic [63:0] REC_NUM = 64'd1 << REC_SH;
    localparam logic [STATE_W:0]   REC_MUL =
        (STATE_W + 1)'((REC_NUM + 64'(SEL_DIV) - 64'd1) / 64'(SEL_DIV));
    localparam logic [TW:0]        DEPTH_W = (TW + 1)'(TABLE_DEPTH);
    localparam logic [TW-1:0]      IDX_TOP = TW'(TABLE_DEPTH - 1);

    // control
    t_state              r_state, n_state;
    logic                r_init;
    logic                r_table_ready;
    logic [CW-1:0]       r_cnt;
    logic [TW-1:0]       r_fill_idx;
    logic                r_out_valid;

    // datapath
    logic [STATE_W-1:0]  r_seed;
    logic [STATE_W-1:0]  r_lcg, n_lcg;
    logic [PROD_W-1:0]   r_prod;
    logic [STATE_W-1:0]  r_last_pick;
    logic [TW-1:0]       r_q;
    logic [STATE_W-1:0]  r_rd;
    logic [STATE_W:0]    r_xh;
    logic [FRAC_W:0]     r_a;
    logic                r_c;
    logic [STATE_W-1:0]  r_out_raw;
    logic [FRAC_W-1:0]   r_out_frac;

    logic [STATE_W-1:0]  mem [TABLE_DEPTH];

    logic                in_xfer;
    logic                out_free;
    logic [STATE_W-1:0]  seed_fixed;
    logic [STATE_W:0]    fold_sum;
    logic                fill_phase;
    logic                last_fill;
    logic                fill_we;
    logic                step_we;
    logic [TW-1:0]       sel_idx;
    logic [2*STATE_W:0]  sel_prod;
    logic [TW-1:0]       sel_q;
    logic [STATE_W:0]    frac_sum;
    logic [FRAC_W+1:0]   frac_q;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_raw_value     = r_out_raw;
    assign o_unit_fraction = r_out_frac;

    // Keep the generator off the zero fixed point
    assign seed_fixed = (r_seed == '0 || r_seed == LCG_MOD) ? SEED_DEFAULT : r_seed;

    // Fold the 46-bit product modulo 2^31 - 1
    assign fold_sum = {1'b0, r_prod[STATE_W-1:0]}
                    + (STATE_W + 1)'(r_prod[PROD_W-1:STATE_W]);
    assign n_lcg    = (fold_sum >= {1'b0, LCG_MOD})
                    ? STATE_W'(fold_sum - {1'b0, LCG_MOD})
                    : fold_sum[STATE_W-1:0];

    // Init step bookkeeping
    assign fill_phase = (r_cnt >= CW'(WARMUP_STEPS));
    assign last_fill  = (r_cnt == CW'(STEPS - 1));
    assign fill_we    = (r_state == S_FOLD) && r_init && fill_phase;
    assign step_we    = (r_state == S_FOLD) && !r_init;

    // Clamp the entry index as a guard
    assign sel_idx = ({1'b0, r_q} >= DEPTH_W) ? IDX_TOP : r_q;

    // Entry index: last pick divided by the bucket size through a rounded-up
    // reciprocal, exact for every 31-bit pick
    assign sel_prod = {{(STATE_W + 1){1'b0}}, r_last_pick} * {{STATE_W{1'b0}}, REC_MUL};
    assign sel_q    = TW'(sel_prod >> REC_SH);

    // Rounded quotient by 2^31 - 1: q = a + (a + b >= M)
    assign frac_sum = (STATE_W + 1)'(r_xh[STATE_W:7])
                    + {1'b0, r_xh[6:0], FRAC_LO_ONES};
    assign frac_q   = {1'b0, r_a} + (FRAC_W + 2)'(r_c);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_reseed || !r_table_ready) ? S_MUL : S_SEL;
                end
            end
            S_SEL: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (!r_init) begin
                    n_state = S_FRAC;
                end else if (last_fill) begin
                    n_state = S_SEL;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_FRAC: begin
                n_state = S_CARRY;
            end
            S_CARRY: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_init        <= 1'b0;
            r_table_ready <= 1'b0;
            r_cnt         <= '0;
            r_fill_idx    <= IDX_TOP;
            r_out_valid   <= 1'b0;
            r_seed        <= SEED_DEFAULT;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_seed <= i_seed_value;
            end
            // start a request: either full init or straight to selection
            if (r_state == S_IDLE && in_xfer) begin
                r_init     <= i_reseed || !r_table_ready;
                r_cnt      <= '0;
                r_fill_idx <= IDX_TOP;
            end
            // advance the init step count and fill pointer
            if (r_state == S_FOLD && r_init) begin
                r_cnt <= r_cnt + 1'b1;
                if (fill_phase) begin
                    r_fill_idx <= r_fill_idx - 1'b1;
                end
                if (last_fill) begin
                    r_init        <= 1'b0;
                    r_table_ready <= 1'b1;
                end
            end
            // hold the result until the receiver takes it
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_xfer) begin
            r_lcg <= (i_reseed || !r_table_ready) ? seed_fixed : r_lcg;
        end
        if (r_state == S_SEL) begin
            r_q <= sel_q;
        end
        if (r_state == S_MUL) begin
            r_prod <= PROD_W'(r_lcg) * PROD_W'(LCG_MULT);
        end
        if (r_state == S_FOLD) begin
            r_lcg <= n_lcg;
            if (r_init && last_fill) begin
                r_last_pick <= n_lcg;
            end
        end
        if (r_state == S_FRAC) begin
            r_last_pick <= r_rd;
            r_xh        <= {1'b0, r_rd} + FRAC_HI_ADD;
        end
        if (r_state == S_CARRY) begin
            r_a <= r_xh[STATE_W:7];
            r_c <= (frac_sum >= {1'b0, LCG_MOD});
        end
        if (r_state == S_OUT && out_free) begin
            r_out_raw  <= r_last_pick;
            r_out_frac <= (frac_q[FRAC_W+1:FRAC_W] != 2'b00) ? '1 : frac_q[FRAC_W-1:0];
        end
    end

    // Shuffle table: fill during init, read-then-replace on each request
    always_ff @(posedge i_clk) begin
        if (fill_we) begin
            mem[r_fill_idx] <= n_lcg;
        end else if (step_we) begin
            r_rd         <= mem[sel_idx];
            mem[sel_idx] <= n_lcg;
        end
    end

    // Once loaded, the table stays loaded until reset
    a_table_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_table_ready |=> r_table_ready)
        else $error("table-loaded flag dropped");

    // The modular fold never yields zero or the modulus
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |-> (n_lcg != '0 && n_lcg != LCG_MOD))
        else $error("generator step left the range 1 .. 2^31-2");

    // The divided index is within the table before the step uses it
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && !r_init) |-> ({1'b0, r_q} < DEPTH_W))
        else $error("table index out of range");

    // A finished result waits while the output register is occupied
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_ready) |=> (r_state == S_OUT))
        else $error("result dropped while output stalled");

    // Delivered deviates are never zero
    a_raw_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_raw_value != '0))
        else $error("zero deviate delivered");

endmodule

### bench/shuffled_lcg_uniform_generator_tb.sv
// Self-checking testbench for the shuffled Lehmer uniform generator.
`timescale 1ns / 100ps

module shuffled_lcg_uniform_generator_tb;
    import slug_pkg::*;

    localparam int unsigned DEPTH      = TABLE_DEPTH_DEF;
    localparam int unsigned IDX_W      = $clog2(DEPTH);
    localparam logic [63:0] MOD64      = {33'd0, LCG_MOD};
    localparam logic [63:0] PICK_DIV   = 64'd1 + (MOD64 - 64'd1) / DEPTH;
    localparam logic [63:0] FRAC_SAT   = {40'd0, FRAC_LO_ONES};
    localparam int unsigned GAP_MAX    = 12;
    localparam int unsigned LONG_HOLD  = 300;

    typedef struct packed {
        logic [STATE_W-1:0] raw;
        logic [FRAC_W-1:0]  frac;
    } deviate_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_seed_we;
    logic [STATE_W-1:0] i_seed_value;
    logic               i_valid;
    logic               o_ready;
    logic               i_reseed;
    logic               o_valid;
    logic               i_ready;
    logic [STATE_W-1:0] o_raw_value;
    logic [FRAC_W-1:0]  o_unit_fraction;

    // Shadow copy of the generator state
    logic [STATE_W-1:0] gen_seed;
    logic [STATE_W-1:0] gen_state;
    logic [STATE_W-1:0] gen_table [DEPTH];
    logic [STATE_W-1:0] gen_last;
    logic               gen_loaded;

    deviate_t    pending_deviates [$];
    int unsigned mismatches;
    int unsigned requests_sent;
    int unsigned reseeds_sent;
    int unsigned deviates_checked;
    int unsigned seed_writes;
    int unsigned send_gap_max;
    int unsigned sink_gap_max;
    int unsigned sink_hold;

    shuffled_lcg_uniform_generator #(
        .TABLE_DEPTH(DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_we      (i_seed_we),
        .i_seed_value   (i_seed_value),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_reseed       (i_reseed),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_raw_value    (o_raw_value),
        .o_unit_fraction(o_unit_fraction)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One Lehmer step: s * 16807 mod (2^31 - 1)
    function automatic logic [STATE_W-1:0] lehmer_next(input logic [STATE_W-1:0] s);
        logic [63:0] prod;
        prod = {33'd0, s} * {49'd0, LCG_MULT};
        return STATE_W'(prod % MOD64);
    endfunction

    // Advance the shadow generator for one request and return its deviate
    task automatic predict_deviate(input logic reseed, output deviate_t d);
        logic [STATE_W-1:0] s;
        logic [63:0]        frac;
        logic [63:0]        quot;
        logic [IDX_W-1:0]   sel;
        int                 n;
        if (reseed || !gen_loaded) begin
            s = gen_seed;
            // zero and the modulus itself would lock the generator at zero
            if (s == '0 || s == LCG_MOD)
                s = SEED_DEFAULT;
            repeat (WARMUP_STEPS) s = lehmer_next(s);
            for (n = DEPTH - 1; n >= 0; n--) begin
                s = lehmer_next(s);
                gen_table[IDX_W'(n)] = s;
            end
            gen_state  = s;
            gen_last   = gen_table[0];
            gen_loaded = 1'b1;
        end
        gen_state = lehmer_next(gen_state);
        quot = {33'd0, gen_last} / PICK_DIV;
        if (quot >= 64'(DEPTH))
            quot = 64'(DEPTH - 1);
        sel = IDX_W'(quot);
        d.raw = gen_table[sel];
        gen_table[sel] = gen_state;
        gen_last = d.raw;
        frac = (({33'd0, d.raw} << FRAC_W) + (MOD64 >> 1)) / MOD64;
        if (frac > FRAC_SAT)
            frac = FRAC_SAT;
        d.frac = frac[FRAC_W-1:0];
    endtask

    // Offer one request after a random gap and hold it until the transfer
    task automatic send_request(input logic reseed);
        int unsigned gap;
        deviate_t    d;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_reseed <= reseed;
        do @(posedge i_clk); while (!o_ready);
        predict_deviate(reseed, d);
        pending_deviates.push_back(d);
        requests_sent++;
        if (reseed)
            reseeds_sent++;
    endtask

    // Drop the request and wait until every pending deviate has arrived
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_deviates.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Seed write; only called while the block is idle
    task automatic write_seed(input logic [STATE_W-1:0] value);
        i_seed_we    <= 1'b1;
        i_seed_value <= value;
        @(posedge i_clk);
        i_seed_we <= 1'b0;
        gen_seed = value;
        seed_writes++;
    endtask

    // First use after reset loads the table from the reset seed
    task automatic test_first_use();
        repeat (4) send_request(1'b0);
        wait_for_drain();
    endtask

    // Seed extremes, including zero and the modulus, each followed by a reseed
    task automatic test_seed_extremes();
        logic [STATE_W-1:0] seeds [6];
        seeds = '{31'd0, LCG_MOD, LCG_MOD - 31'd1, 31'd1, 31'h2AAA_AAAA, 31'h5555_5555};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_request(1'b1);
            send_request(1'b0);
            send_request(1'b0);
            wait_for_drain();
        end
        // back-to-back reseeds restart the same sequence
        send_request(1'b1);
        send_request(1'b1);
        wait_for_drain();
    endtask

    // Long random stream in segments, with a fresh seed between segments
    task automatic test_random_stream();
        logic [STATE_W-1:0] corner [4];
        logic [STATE_W-1:0] seed;
        corner = '{31'd0, 31'd1, LCG_MOD - 31'd1, LCG_MOD};
        for (int seg = 0; seg < 7; seg++) begin
            if ($urandom_range(0, 3) == 0)
                seed = corner[2'($urandom_range(0, 3))];
            else
                seed = STATE_W'($urandom);
            write_seed(seed);
            // vary idling: none on either side, a fast sender, a fast receiver, or full idling
            case (seg)
                2: begin
                    send_gap_max = 0;
                    sink_gap_max = 0;
                end
                4: begin
                    send_gap_max = 0;
                    sink_gap_max = GAP_MAX;
                end
                5: begin
                    send_gap_max = GAP_MAX;
                    sink_gap_max = 0;
                end
                default: begin
                    send_gap_max = GAP_MAX;
                    sink_gap_max = GAP_MAX;
                end
            endcase
            for (int k = 0; k < 100; k++)
                send_request($urandom_range(0, 24) == 0);
            wait_for_drain();
        end
        send_gap_max = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    // Receiver holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        sink_hold = LONG_HOLD;
        send_gap_max = 0;
        for (int k = 0; k < 40; k++)
            send_request($urandom_range(0, 9) == 0);
        send_gap_max = GAP_MAX;
        wait_for_drain();
    endtask

    // Sender pauses until all deviates are back every few requests
    task automatic test_drain_pause();
        for (int k = 0; k < 30; k++) begin
            send_request($urandom_range(0, 9) == 0);
            if (k % 6 == 5)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // Result receiver with random stalls and an occasional long hold-off
    initial begin : result_sink
        int unsigned pause;
        i_ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (sink_hold != 0) begin
                pause = sink_hold;
                sink_hold = 0;
            end else begin
                pause = $urandom_range(0, sink_gap_max);
            end
            if (pause > 0) begin
                i_ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare every transferred deviate with the oldest prediction
    always @(posedge i_clk) begin
        deviate_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_deviates.size() == 0) begin
                $error("unexpected deviate: raw_value %0d, unit_fraction %0d",
                       o_raw_value, o_unit_fraction);
                mismatches++;
            end else begin
                want = pending_deviates.pop_front();
                deviates_checked++;
                if (o_raw_value !== want.raw) begin
                    $error("raw_value: expected %0d, got %0d", want.raw, o_raw_value);
                    mismatches++;
                end
                if (o_unit_fraction !== want.frac) begin
                    $error("unit_fraction: expected %0d, got %0d",
                           want.frac, o_unit_fraction);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("shuffled_lcg_uniform_generator_tb: FAIL");
        $finish;
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_seed_we    = 1'b0;
        i_seed_value = SEED_DEFAULT;
        i_valid      = 1'b0;
        i_reseed     = 1'b0;
        gen_seed     = SEED_DEFAULT;
        gen_state    = SEED_DEFAULT;
        gen_last     = '0;
        gen_loaded   = 1'b0;
        foreach (gen_table[i]) gen_table[i] = '0;
        mismatches       = 0;
        requests_sent    = 0;
        reseeds_sent     = 0;
        deviates_checked = 0;
        seed_writes      = 0;
        send_gap_max     = GAP_MAX;
        sink_gap_max     = GAP_MAX;
        sink_hold        = 0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_use();
        test_seed_extremes();
        test_random_stream();
        test_output_backpressure();
        test_drain_pause();

        wait_for_drain();
        repeat (30) @(posedge i_clk);

        $display("Covered %0d requests (%0d reseeds) and %0d seed writes incl. 0 and 2^31-1;",
                 requests_sent, reseeds_sent, seed_writes);
        $display("%0d deviates checked under random stalls and a long output hold-off.",
                 deviates_checked);
        if (mismatches == 0)
            $display("shuffled_lcg_uniform_generator_tb: PASS");
        else
            $display("shuffled_lcg_uniform_generator_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/slug_pkg.sv
rtl/shuffled_lcg_uniform_generator.sv
bench/shuffled_lcg_uniform_generator_tb.sv
